### rtl/vfct_pkg.sv
// ----------------------------------------------------------------------------
// vfct_pkg
// Shared constants, codes and types of the view frustum culling test core.
// ----------------------------------------------------------------------------
`default_nettype none

package vfct_pkg;

   // Default field widths
   localparam int COORD_WIDTH_DEF = 20;
   localparam int AXIS_WIDTH_DEF  = 16;

   // Fixed field widths
   localparam int SCALE_W    = 12;
   localparam int SLOPE_W    = 16;
   localparam int CAMERA_W   = 60;
   localparam int AXIS_REG_W = 48;
   localparam int DEPTH_W    = 40;
   localparam int CSR_DATA_W = 60;
   localparam int CSR_IDX_W  = 3;

   // Fixed-point fractions
   localparam int AXIS_FRAC  = 14;   // axis components Q1.14
   localparam int SLOPE_FRAC = 12;   // slopes Q4.12
   localparam int SR_SHIFT   = 4;    // Q.14 * Q.12 -> Q.26, then shifted left by 4

   // sqrt(2) in Q.14
   localparam int SQRT2_W = 15;
   localparam logic [SQRT2_W-1:0] SQRT2_Q14 = 15'd23170;
   localparam int RADIUS_W = SCALE_W + SQRT2_W;

   localparam int STAGES = 5;

   localparam logic [SLOPE_W-1:0] SLOPE_ONE = 16'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAMERA_POSITION  = 3'd0,
      CSR_RIGHT_AXIS       = 3'd1,
      CSR_UP_AXIS          = 3'd2,
      CSR_VIEW_AXIS        = 3'd3,
      CSR_DEPTH_LIMITS     = 3'd4,
      CSR_VERTICAL_SLOPE   = 3'd5,
      CSR_HORIZONTAL_SLOPE = 3'd6,
      CSR_SPHERE_FACTOR    = 3'd7
   } csr_index_type;

   typedef enum logic {
      CMD_CUBE   = 1'b0,
      CMD_SQUARE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      COLL_OUTSIDE   = 2'd0,
      COLL_INSIDE    = 2'd1,
      COLL_INTERSECT = 2'd2
   } collision_type;

   typedef struct packed {
      logic [CAMERA_W-1:0]   camera_position;
      logic [AXIS_REG_W-1:0] right_axis;
      logic [AXIS_REG_W-1:0] up_axis;
      logic [AXIS_REG_W-1:0] view_axis;
      logic [DEPTH_W-1:0]    depth_limits;
      logic [SLOPE_W-1:0]    vertical_slope;
      logic [SLOPE_W-1:0]    horizontal_slope;
      logic [SLOPE_W-1:0]    sphere_factor;
   } csr_regs_type;

endpackage

`default_nettype wire

### rtl/vfct_if.sv
// ----------------------------------------------------------------------------
// vfct interfaces
// Valid/ready channels: test request, test response and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfct_req_if #(
   parameter int COORD_WIDTH = vfct_pkg::COORD_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic signed [COORD_WIDTH-1:0]     point_x;
   logic signed [COORD_WIDTH-1:0]     point_y;
   logic signed [COORD_WIDTH-1:0]     point_z;
   logic [vfct_pkg::SCALE_W-1:0]      scale;

   modport source (output valid, command, point_x, point_y, point_z, scale,
                   input ready);
   modport sink   (input valid, command, point_x, point_y, point_z, scale,
                   output ready);
endinterface

interface vfct_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] collision;
   logic       visible;

   modport source (output valid, collision, visible, input ready);
   modport sink   (input valid, collision, visible, output ready);
endinterface

interface vfct_csr_if;
   logic                              valid;
   logic                              ready;
   logic [vfct_pkg::CSR_IDX_W-1:0]    index;
   logic [vfct_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/vfct_csr.sv
// ----------------------------------------------------------------------------
// vfct_csr
// Camera and frustum configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vfct_csr (
   input  wire                    clock,
   input  wire                    reset,
   vfct_csr_if.sink               csr_bus,
   output vfct_pkg::csr_regs_type regs
);

   // slopes and sphere factor come up at 1.0, everything else at zero
   localparam vfct_pkg::csr_regs_type REGS_RESET = '{
      camera_position:  '0,
      right_axis:       '0,
      up_axis:          '0,
      view_axis:        '0,
      depth_limits:     '0,
      vertical_slope:   vfct_pkg::SLOPE_ONE,
      horizontal_slope: vfct_pkg::SLOPE_ONE,
      sphere_factor:    vfct_pkg::SLOPE_ONE
   };

   vfct_pkg::csr_regs_type regs_ff;
   vfct_pkg::csr_regs_type regs_in;

   assign csr_bus.ready = 1'b1;
   assign regs          = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (csr_bus.valid) begin
         case (vfct_pkg::csr_index_type'(csr_bus.index))
            vfct_pkg::CSR_CAMERA_POSITION:
               regs_in.camera_position = csr_bus.data[vfct_pkg::CAMERA_W-1:0];
            vfct_pkg::CSR_RIGHT_AXIS:
               regs_in.right_axis = csr_bus.data[vfct_pkg::AXIS_REG_W-1:0];
            vfct_pkg::CSR_UP_AXIS:
               regs_in.up_axis = csr_bus.data[vfct_pkg::AXIS_REG_W-1:0];
            vfct_pkg::CSR_VIEW_AXIS:
               regs_in.view_axis = csr_bus.data[vfct_pkg::AXIS_REG_W-1:0];
            vfct_pkg::CSR_DEPTH_LIMITS:
               regs_in.depth_limits = csr_bus.data[vfct_pkg::DEPTH_W-1:0];
            vfct_pkg::CSR_VERTICAL_SLOPE:
               regs_in.vertical_slope = csr_bus.data[vfct_pkg::SLOPE_W-1:0];
            vfct_pkg::CSR_HORIZONTAL_SLOPE:
               regs_in.horizontal_slope = csr_bus.data[vfct_pkg::SLOPE_W-1:0];
            vfct_pkg::CSR_SPHERE_FACTOR:
               regs_in.sphere_factor = csr_bus.data[vfct_pkg::SLOPE_W-1:0];
            default: regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REGS_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

`default_nettype wire

### rtl/vfct_pipe.sv
// ----------------------------------------------------------------------------
// vfct_pipe
// Five-stage culling datapath: offset, products, sums, bounds, compare.
// ----------------------------------------------------------------------------
`default_nettype none

module vfct_pipe #(
   parameter int COORD_WIDTH = vfct_pkg::COORD_WIDTH_DEF,
   parameter int AXIS_WIDTH  = vfct_pkg::AXIS_WIDTH_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire vfct_pkg::csr_regs_type regs,
   vfct_req_if.sink                    req_bus,
   vfct_rsp_if.source                  rsp_bus
);

   localparam int CW    = COORD_WIDTH;
   localparam int AW    = AXIS_WIDTH;
   localparam int DW    = CW + 1;                 // point - camera
   localparam int PW    = DW + AW;                // one product
   localparam int SUMW  = PW + 2;                 // three-term dot product
   localparam int SW    = SUMW + 2;               // signed depth compare
   localparam int DEPW  = CW + vfct_pkg::AXIS_FRAC;
   localparam int RADW  = vfct_pkg::RADIUS_W;
   localparam int SRW   = RADW + vfct_pkg::SLOPE_W;
   localparam int R18W  = RADW + vfct_pkg::SR_SHIFT;
   localparam int BW    = DEPW + vfct_pkg::SLOPE_W + 2;
   localparam int MAGSH = SUMW + vfct_pkg::SLOPE_FRAC;
   localparam int CMPW  = ((MAGSH > BW) ? MAGSH : BW) + 1;
   localparam int CAMW  = 3 * CW;
   localparam int AXW   = 3 * AW;
   localparam int DLW   = 2 * CW;
   localparam int NS    = vfct_pkg::STAGES;

   // ---------------- configuration fields ----------------
   logic [CAMW-1:0]        cam_ext;
   logic [AXW-1:0]         axis_ext [3];     // right, up, view
   logic [DLW-1:0]         depth_ext;
   logic signed [CW-1:0]   cam [3];
   logic signed [AW-1:0]   axis_c [3][3];
   logic [CW-1:0]          near_d;
   logic [CW-1:0]          far_d;
   logic signed [SW-1:0]   near_q;
   logic signed [SW-1:0]   far_q;

   assign cam_ext     = CAMW'(regs.camera_position);
   assign axis_ext[0] = AXW'(regs.right_axis);
   assign axis_ext[1] = AXW'(regs.up_axis);
   assign axis_ext[2] = AXW'(regs.view_axis);
   assign depth_ext   = DLW'(regs.depth_limits);
   assign near_d      = depth_ext[CW-1:0];
   assign far_d       = depth_ext[DLW-1:CW];
   assign near_q      = $signed(SW'({near_d, {vfct_pkg::AXIS_FRAC{1'b0}}}));
   assign far_q       = $signed(SW'({far_d, {vfct_pkg::AXIS_FRAC{1'b0}}}));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cam[i] = cam_ext[i*CW +: CW];
         for (int a = 0; a < 3; a++) begin
            axis_c[a][i] = axis_ext[a][i*AW +: AW];
         end
      end
   end

   // ---------------- flow control ----------------
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] move;

   always_comb begin
      move[NS-1] = !valid_ff[NS-1] || rsp_bus.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
   end

   assign req_bus.ready = move[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (move[0]) begin
            valid_ff[0] <= req_bus.valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (move[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // ---------------- stage 1: offset from camera ----------------
   logic signed [CW-1:0]           pt [3];
   logic signed [DW-1:0]           d_in [3];
   logic signed [DW-1:0]           d_ff [3];
   logic                           cmd_ff1;
   logic [vfct_pkg::SCALE_W-1:0]   scale_ff1;

   assign pt[0] = req_bus.point_x;
   assign pt[1] = req_bus.point_y;
   assign pt[2] = req_bus.point_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = DW'(pt[i]) - DW'(cam[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         d_ff      <= d_in;
         cmd_ff1   <= req_bus.command;
         scale_ff1 <= req_bus.scale;
      end
   end

   // ---------------- stage 2: axis products, radius ----------------
   logic signed [PW-1:0] prod_in [3][3];
   logic signed [PW-1:0] prod_ff [3][3];
   logic [RADW-1:0]      radius_in;
   logic [RADW-1:0]      radius_ff2;
   logic                 cmd_ff2;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[a][i] = d_ff[i] * axis_c[a][i];
         end
      end
   end

   assign radius_in = RADW'(scale_ff1) * RADW'(vfct_pkg::SQRT2_Q14);

   always_ff @(posedge clock) begin
      if (move[1]) begin
         prod_ff    <= prod_in;
         radius_ff2 <= radius_in;
         cmd_ff2    <= cmd_ff1;
      end
   end

   // ---------------- stage 3: dot products, sphere term ----------------
   logic signed [SUMW-1:0] sum_in [3];
   logic signed [SUMW-1:0] sum_ff [3];
   logic signed [SUMW-1:0] sq_az_in;
   logic signed [SUMW-1:0] sq_az_ff;
   logic [SRW-1:0]         sr_in;
   logic [SRW-1:0]         sr_ff;
   logic [R18W-1:0]        r18_ff;
   logic                   cmd_ff3;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = SUMW'(prod_ff[a][0]) + SUMW'(prod_ff[a][1]) + SUMW'(prod_ff[a][2]);
      end
   end

   // square test: x and z of the view axis only
   assign sq_az_in = SUMW'(prod_ff[2][0]) + SUMW'(prod_ff[2][2]);
   assign sr_in    = SRW'(radius_ff2) * SRW'(regs.sphere_factor);

   always_ff @(posedge clock) begin
      if (move[2]) begin
         sum_ff   <= sum_in;
         sq_az_ff <= sq_az_in;
         sr_ff    <= sr_in;
         r18_ff   <= {radius_ff2, {vfct_pkg::SR_SHIFT{1'b0}}};
         cmd_ff3  <= cmd_ff2;
      end
   end

   // ---------------- stage 4: depth checks, slope bounds ----------------
   logic signed [SW-1:0]  az_w;
   logic signed [SW-1:0]  sq_az_w;
   logic signed [SW-1:0]  r18_w;
   logic [DEPW-1:0]       az_low;
   logic [BW-1:0]         sr_w;
   logic                  depth_ok_in;
   logic                  sq_hit_in;
   logic [BW-1:0]         by_in;
   logic [BW-1:0]         bx_in;
   logic [SUMW-1:0]       mag_up_in;
   logic [SUMW-1:0]       mag_rt_in;
   logic                  depth_ok_ff;
   logic                  sq_hit_ff;
   logic [BW-1:0]         by_ff;
   logic [BW-1:0]         bx_ff;
   logic [SUMW-1:0]       mag_up_ff;
   logic [SUMW-1:0]       mag_rt_ff;
   logic                  cmd_ff4;

   assign az_w    = SW'(sum_ff[2]);
   assign sq_az_w = SW'(sq_az_ff);
   assign r18_w   = $signed(SW'(r18_ff));
   assign az_low  = sum_ff[2][DEPW-1:0];   // only used when 0 <= az <= far
   assign sr_w    = BW'({sr_ff, {vfct_pkg::SR_SHIFT{1'b0}}});

   assign depth_ok_in = (az_w >= near_q) && (az_w <= far_q) && (az_w >= 0);
   assign sq_hit_in   = !((sq_az_w > far_q + r18_w) || (sq_az_w < near_q - r18_w));
   assign by_in       = BW'(az_low) * BW'(regs.vertical_slope) + sr_w;
   assign bx_in       = BW'(az_low) * BW'(regs.horizontal_slope) + sr_w;
   assign mag_up_in   = sum_ff[1][SUMW-1] ? SUMW'(~sum_ff[1]) + SUMW'(1)
                                          : SUMW'(sum_ff[1]);
   assign mag_rt_in   = sum_ff[0][SUMW-1] ? SUMW'(~sum_ff[0]) + SUMW'(1)
                                          : SUMW'(sum_ff[0]);

   always_ff @(posedge clock) begin
      if (move[3]) begin
         depth_ok_ff <= depth_ok_in;
         sq_hit_ff   <= sq_hit_in;
         by_ff       <= by_in;
         bx_ff       <= bx_in;
         mag_up_ff   <= mag_up_in;
         mag_rt_ff   <= mag_rt_in;
         cmd_ff4     <= cmd_ff3;
      end
   end

   // ---------------- stage 5: bound compare, result word ----------------
   logic                    beyond_up;
   logic                    beyond_rt;
   vfct_pkg::collision_type coll_in;
   vfct_pkg::collision_type coll_ff;

   assign beyond_up = CMPW'({mag_up_ff, {vfct_pkg::SLOPE_FRAC{1'b0}}}) > CMPW'(by_ff);
   assign beyond_rt = CMPW'({mag_rt_ff, {vfct_pkg::SLOPE_FRAC{1'b0}}}) > CMPW'(bx_ff);

   always_comb begin
      if (cmd_ff4 == vfct_pkg::CMD_SQUARE) begin
         coll_in = sq_hit_ff ? vfct_pkg::COLL_INTERSECT : vfct_pkg::COLL_OUTSIDE;
      end else begin
         coll_in = (depth_ok_ff && !beyond_up && !beyond_rt) ? vfct_pkg::COLL_INSIDE
                                                             : vfct_pkg::COLL_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (move[4]) begin
         coll_ff <= coll_in;
      end
   end

   assign rsp_bus.valid     = valid_ff[NS-1];
   assign rsp_bus.collision = coll_ff;
   assign rsp_bus.visible   = (coll_ff != vfct_pkg::COLL_OUTSIDE);

endmodule

`default_nettype wire

### rtl/view_frustum_culling_test_core.sv
// ----------------------------------------------------------------------------
// view_frustum_culling_test_core
// Sphere-against-frustum culling of cube and square nodes, one word a cycle while rsp_bus is not stalled.
// ----------------------------------------------------------------------------
//
//  channel   dir  modport  word contents
//  --------  ---  -------  ---------------------------------------------
//  req_bus   in   sink     command, point_x, point_y, point_z, scale
//  rsp_bus   out  source   collision, visible
//  csr_bus   in   sink     index, data (register write)
//
//  Throughput: one request word per cycle while rsp_bus is not stalled;
//  a word reaches rsp_bus.valid through the five register stages of vfct_pipe.
//  Each stage has its own valid bit; a stage loads when it is empty or the
//  stage after it moves, so bubbles close up while rsp_bus is stalled.
//  Reset (synchronous, active high) empties the pipe and loads register
//  defaults: slopes and sphere factor 1.0, all others zero.
//  csr_bus is always ready; write registers only while the pipe is empty.
//
`default_nettype none

module view_frustum_culling_test_core #(
   parameter int COORD_WIDTH = vfct_pkg::COORD_WIDTH_DEF,
   parameter int AXIS_WIDTH  = vfct_pkg::AXIS_WIDTH_DEF
) (
   input  wire        clock,
   input  wire        reset,
   vfct_req_if.sink   req_bus,
   vfct_rsp_if.source rsp_bus,
   vfct_csr_if.sink   csr_bus
);

   // camera, axes, depth limits, slopes
   vfct_pkg::csr_regs_type regs;

   vfct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .regs    (regs)
   );

   // offset -> products -> dot sums -> bounds -> compare
   vfct_pipe #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS_WIDTH  (AXIS_WIDTH)
   ) u_pipe (
      .clock   (clock),
      .reset   (reset),
      .regs    (regs),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // ---------------- assertions ----------------

   // visible flag tracks the collision code
   a_visible_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.visible == (rsp_bus.collision != vfct_pkg::COLL_OUTSIDE)))
      else $error("visible disagrees with collision");

   // a draining output means the whole pipe can take a word
   a_ready_when_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.ready |-> req_bus.ready)
      else $error("request stalled while response side is ready");

   // with no back-pressure, an accepted word reaches the output through every pipe stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ($past(req_bus.valid && req_bus.ready, 5) && !$past(reset, 5) &&
       !$past(reset, 4) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1) &&
       $past(rsp_bus.ready, 4) && $past(rsp_bus.ready, 3) &&
       $past(rsp_bus.ready, 2) && $past(rsp_bus.ready, 1)) |-> rsp_bus.valid)
      else $error("accepted word did not reach the output in time");

endmodule

`default_nettype wire
